FILE: hdl/i2cms_pkg.sv
package i2cms_pkg;

   // defaults for the top level parameters and the register
   localparam int unsigned DELAY_WIDTH_DEF = 16;
   localparam int unsigned HALF_PERIOD_W   = 16;
   localparam logic [HALF_PERIOD_W-1:0] HALF_PERIOD_RESET = 16'd50;
   localparam int unsigned BITS_PER_BYTE   = 8;

   // command codes
   localparam logic [1:0] ACT_START = 2'd0;
   localparam logic [1:0] ACT_STOP  = 2'd1;
   localparam logic [1:0] ACT_WRITE = 2'd2;
   localparam logic [1:0] ACT_READ  = 2'd3;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE  = 4'd0,
      ST_S1    = 4'd1,
      ST_S2    = 4'd2,
      ST_P1    = 4'd3,
      ST_WHIGH = 4'd4,
      ST_WLOW  = 4'd5,
      ST_WACK  = 4'd6,
      ST_RHIGH = 4'd7,
      ST_RLOW  = 4'd8,
      ST_RACKH = 4'd9,
      ST_RACKL = 4'd10
   } seq_state_type;

   // one result word
   typedef struct packed {
      logic       scl_drive_low;
      logic       sda_drive_low;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       ack_seen;
   } rsp_type;

endpackage

FILE: hdl/i2cms_if.sv
// command / line sample channel
interface i2cms_req_if;
   logic       valid;
   logic       ready;
   logic       cmd_valid;
   logic [1:0] action;
   logic [7:0] tx_byte;
   logic       send_nack;
   logic       sda_in;

   modport source (output valid, cmd_valid, action, tx_byte, send_nack, sda_in,
                   input ready);
   modport sink   (input valid, cmd_valid, action, tx_byte, send_nack, sda_in,
                   output ready);
endinterface

// line drive / status channel
interface i2cms_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_drive_low;
   logic       sda_drive_low;
   logic       busy_res;
   logic       done_res;
   logic [7:0] rx_byte;
   logic       ack_seen;

   modport source (output valid, scl_drive_low, sda_drive_low, busy_res, done_res,
                   rx_byte, ack_seen, input ready);
   modport sink   (input valid, scl_drive_low, sda_drive_low, busy_res, done_res,
                   rx_byte, ack_seen, output ready);
endinterface

// half period register write channel
interface i2cms_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

FILE: hdl/i2c_master_byte_sequencer.sv
// result: a word's result is in the output register from the cycle after it is accepted
// throughput: one word (one bus tick) per cycle; the result register with its
//   free-or-draining ready sets that figure, so the block stalls only on rsp backpressure
// reset: synchronous, active high; sequencer idle, both lines released,
//   half period back to 50 ticks, received byte and ack flag cleared
module i2c_master_byte_sequencer
   import i2cms_pkg::*;
#(
   parameter int unsigned DELAY_WIDTH = DELAY_WIDTH_DEF
)(
   input logic        clock,
   input logic        reset,
   i2cms_req_if.sink   req_ch,
   i2cms_rsp_if.source rsp_ch,
   i2cms_csr_if.sink   csr_ch
);

   localparam int unsigned CMP_W = (DELAY_WIDTH > HALF_PERIOD_W) ? DELAY_WIDTH
                                                                 : HALF_PERIOD_W;

   logic [HALF_PERIOD_W-1:0] half_period_ff;
   seq_state_type            state_ff, state_in;
   logic [DELAY_WIDTH-1:0]   phase_ff, phase_in;
   logic [3:0]               bit_ff, bit_in;
   logic [7:0]               shift_ff, shift_in;
   logic                     nack_ff, nack_in;
   logic                     scl_low_ff, scl_low_in;
   logic                     sda_low_ff, sda_low_in;
   logic                     ack_ff, ack_in;
   logic [7:0]               rx_ff, rx_in;
   logic                     done_in;

   logic                     step;
   logic                     can_load;
   logic                     timeout;
   logic                     last_bit;
   logic                     idle_st;
   logic [CMP_W-1:0]         hp_ext;
   logic [CMP_W-1:0]         lim_ext;
   logic [DELAY_WIDTH-1:0]   period;
   logic [DELAY_WIDTH-1:0]   reload;
   rsp_type                  rsp_in;
   rsp_type                  rsp_out;

   // config register, always writable
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= HALF_PERIOD_RESET;
      end else if (csr_ch.valid) begin
         half_period_ff <= csr_ch.data;
      end
   end

   // effective period: zero reads as one, saturate at counter limit
   assign hp_ext  = CMP_W'(half_period_ff);
   assign lim_ext = CMP_W'({DELAY_WIDTH{1'b1}});

   always_comb begin
      if (hp_ext > lim_ext) begin
         period = {DELAY_WIDTH{1'b1}};
      end else if (hp_ext == '0) begin
         period = DELAY_WIDTH'(1);
      end else begin
         period = DELAY_WIDTH'(hp_ext);
      end
   end

   assign reload   = period - DELAY_WIDTH'(1);
   assign timeout  = (phase_ff == '0);
   assign last_bit = (bit_ff == 4'(BITS_PER_BYTE - 1));

   // unused state codes act as idle
   assign idle_st  = (state_ff == ST_IDLE) || (state_ff > ST_RACKL);

   assign step         = req_ch.valid && can_load;
   assign req_ch.ready = can_load;

   // next state, counters and shift register
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      nack_in  = nack_ff;
      if (idle_st) begin
         state_in = ST_IDLE;
         if (req_ch.cmd_valid) begin
            phase_in = reload;
            unique case (req_ch.action)
               ACT_START: state_in = ST_S1;
               ACT_STOP:  state_in = ST_P1;
               ACT_WRITE: begin
                  state_in = ST_WHIGH;
                  shift_in = req_ch.tx_byte;
                  bit_in   = '0;
               end
               default: begin
                  state_in = ST_RHIGH;
                  nack_in  = req_ch.send_nack;
                  shift_in = '0;
                  bit_in   = '0;
               end
            endcase
         end
      end else begin
         if (!timeout) begin
            phase_in = phase_ff - DELAY_WIDTH'(1);
         end else begin
            phase_in = reload;
            unique case (state_ff)
               ST_S1:    state_in = ST_S2;
               ST_WHIGH: state_in = ST_WLOW;
               ST_WLOW: begin
                  shift_in = {shift_ff[6:0], 1'b0};
                  bit_in   = bit_ff + 4'd1;
                  state_in = last_bit ? ST_WACK : ST_WHIGH;
               end
               ST_RHIGH: begin
                  shift_in = {shift_ff[6:0], req_ch.sda_in};
                  state_in = ST_RLOW;
               end
               ST_RLOW: begin
                  bit_in   = bit_ff + 4'd1;
                  state_in = last_bit ? ST_RACKH : ST_RHIGH;
               end
               ST_RACKH: state_in = ST_RACKL;
               default:  state_in = ST_IDLE;
            endcase
         end
      end
   end

   // line drive, done, ack and received byte
   always_comb begin
      scl_low_in = scl_low_ff;
      sda_low_in = sda_low_ff;
      ack_in     = ack_ff;
      rx_in      = rx_ff;
      done_in    = 1'b0;
      if (idle_st) begin
         if (req_ch.cmd_valid) begin
            scl_low_in = 1'b0;
            unique case (req_ch.action)
               ACT_START: sda_low_in = 1'b0;
               ACT_STOP:  sda_low_in = sda_low_ff;
               ACT_WRITE: sda_low_in = !req_ch.tx_byte[7];
               default:   sda_low_in = 1'b0;
            endcase
         end
      end else begin
         if (timeout) begin
            unique case (state_ff)
               ST_S1: begin
                  sda_low_in = 1'b1;
               end
               ST_S2: begin
                  scl_low_in = 1'b1;
                  sda_low_in = 1'b1;
                  done_in    = 1'b1;
               end
               ST_P1: begin
                  scl_low_in = 1'b0;
                  sda_low_in = 1'b0;
                  done_in    = 1'b1;
               end
               ST_WHIGH, ST_RHIGH, ST_RACKH: begin
                  scl_low_in = 1'b1;
               end
               ST_WLOW: begin
                  scl_low_in = 1'b0;
                  sda_low_in = last_bit ? 1'b0 : !shift_ff[6];
               end
               ST_WACK: begin
                  ack_in     = !req_ch.sda_in;
                  scl_low_in = 1'b1;
                  sda_low_in = 1'b1;
                  done_in    = 1'b1;
               end
               ST_RLOW: begin
                  scl_low_in = 1'b0;
                  sda_low_in = last_bit ? !nack_ff : 1'b0;
               end
               ST_RACKL: begin
                  scl_low_in = 1'b1;
                  sda_low_in = 1'b1;
                  rx_in      = shift_ff;
                  done_in    = 1'b1;
               end
               default: begin
                  scl_low_in = scl_low_ff;
               end
            endcase
         end
      end
   end

   // sequencer registers advance once per accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         phase_ff   <= '0;
         bit_ff     <= '0;
         shift_ff   <= '0;
         nack_ff    <= 1'b0;
         scl_low_ff <= 1'b0;
         sda_low_ff <= 1'b0;
         ack_ff     <= 1'b0;
         rx_ff      <= '0;
      end else if (step) begin
         state_ff   <= state_in;
         phase_ff   <= phase_in;
         bit_ff     <= bit_in;
         shift_ff   <= shift_in;
         nack_ff    <= nack_in;
         scl_low_ff <= scl_low_in;
         sda_low_ff <= sda_low_in;
         ack_ff     <= ack_in;
         rx_ff      <= rx_in;
      end
   end

   // result word
   always_comb begin
      rsp_in.scl_drive_low = scl_low_in;
      rsp_in.sda_drive_low = sda_low_in;
      rsp_in.busy_res      = (state_in != ST_IDLE);
      rsp_in.done_res      = done_in;
      rsp_in.rx_byte       = rx_in;
      rsp_in.ack_seen      = ack_in;
   end

   i2cms_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (step),
      .load_data (rsp_in),
      .can_load  (can_load),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (rsp_out)
   );

   assign rsp_ch.scl_drive_low = rsp_out.scl_drive_low;
   assign rsp_ch.sda_drive_low = rsp_out.sda_drive_low;
   assign rsp_ch.busy_res      = rsp_out.busy_res;
   assign rsp_ch.done_res      = rsp_out.done_res;
   assign rsp_ch.rx_byte       = rsp_out.rx_byte;
   assign rsp_ch.ack_seen      = rsp_out.ack_seen;

`ifndef SYNTH
   // a finishing word never reports busy
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.done_res |-> !rsp_ch.busy_res)
      else $error("done word reported busy");

   // bit counter never runs past the ack bit
   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      bit_ff <= 4'(BITS_PER_BYTE))
      else $error("bit counter out of range");

   // an accepted command always leaves idle
   a_cmd_starts: assert property (@(posedge clock) disable iff (reset)
      step && (state_ff == ST_IDLE) && req_ch.cmd_valid |=> (state_ff != ST_IDLE))
      else $error("command did not start sequencer");

   // sequencer state only moves on accepted words
   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(state_ff) && $stable(phase_ff))
      else $error("sequencer moved without an accepted word");
`endif

endmodule

FILE: hdl/i2cms_out_reg.sv
module i2cms_out_reg
   import i2cms_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type load_data,
   output logic    can_load,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   // free when empty or being drained this cycle
   assign can_load = !valid_ff || out_ready;
   assign valid_in = load || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload holds while stalled
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: bench/i2cms_tb_pkg.sv
package i2cms_tb_pkg;
   import i2cms_pkg::*;

   // one bus tick word as the bench offers it
   typedef struct packed {
      logic       cmd_valid;
      logic [1:0] action;
      logic [7:0] tx_byte;
      logic       send_nack;
      logic       sda_in;
   } tick_word_type;

   // line sequencer shadow plus the queue of line / status words it predicts
   class i2c_tick_scoreboard;
      logic [HALF_PERIOD_W-1:0]   half_period;
      seq_state_type              seq;
      logic [DELAY_WIDTH_DEF-1:0] ticks_left;
      logic [3:0]                 bits_done;
      logic [7:0]                 shifter;
      logic                       nack_held;
      logic                       scl_low;
      logic                       sda_low;
      logic                       ack_held;
      logic [7:0]                 rx_held;
      rsp_type                    line_q[$];
      int                         errors;

      function new();
         half_period = HALF_PERIOD_RESET;
         seq         = ST_IDLE;
         ticks_left  = '0;
         bits_done   = '0;
         shifter     = '0;
         nack_held   = 1'b0;
         scl_low     = 1'b0;
         sda_low     = 1'b0;
         ack_held    = 1'b0;
         rx_held     = '0;
         errors      = 0;
      endfunction

      function void set_half_period(input logic [HALF_PERIOD_W-1:0] value);
         half_period = value;
      endfunction

      function bit idle();
         return seq == ST_IDLE;
      endfunction

      function int pending();
         return line_q.size();
      endfunction

      function void flag(input string msg);
         errors++;
         if (errors <= 10) $display("%s", msg);
      endfunction

      // move to a state and load the phase counter; a zero period acts as one
      function void enter(input seq_state_type next);
         seq = next;
         ticks_left = (half_period == '0) ? '0 : half_period - 1'b1;
      endfunction

      // advance the shadow by one tick and queue the line word it gives
      function void note_word(input tick_word_type w);
         logic done;
         done = 1'b0;
         if (seq == ST_IDLE) begin
            if (w.cmd_valid) begin
               case (w.action)
                  ACT_START: begin
                     scl_low = 1'b0;
                     sda_low = 1'b0;
                     enter(ST_S1);
                  end
                  ACT_STOP: begin
                     scl_low = 1'b0;
                     enter(ST_P1);
                  end
                  ACT_WRITE: begin
                     shifter   = w.tx_byte;
                     bits_done = '0;
                     scl_low   = 1'b0;
                     sda_low   = !shifter[7];
                     enter(ST_WHIGH);
                  end
                  default: begin
                     nack_held = w.send_nack;
                     shifter   = '0;
                     bits_done = '0;
                     scl_low   = 1'b0;
                     sda_low   = 1'b0;
                     enter(ST_RHIGH);
                  end
               endcase
            end
         end else if (ticks_left != '0) begin
            ticks_left--;
         end else begin
            case (seq)
               ST_S1: begin
                  scl_low = 1'b0;
                  sda_low = 1'b1;
                  enter(ST_S2);
               end
               ST_S2: begin
                  scl_low = 1'b1;
                  sda_low = 1'b1;
                  seq     = ST_IDLE;
                  done    = 1'b1;
               end
               ST_P1: begin
                  scl_low = 1'b0;
                  sda_low = 1'b0;
                  seq     = ST_IDLE;
                  done    = 1'b1;
               end
               ST_WHIGH: begin
                  scl_low = 1'b1;
                  enter(ST_WLOW);
               end
               ST_WLOW: begin
                  shifter   = shifter << 1;
                  bits_done = bits_done + 1'b1;
                  scl_low   = 1'b0;
                  if (bits_done < BITS_PER_BYTE) begin
                     sda_low = !shifter[7];
                     enter(ST_WHIGH);
                  end else begin
                     sda_low = 1'b0;
                     enter(ST_WACK);
                  end
               end
               ST_WACK: begin
                  ack_held = !w.sda_in;
                  scl_low  = 1'b1;
                  sda_low  = 1'b1;
                  seq      = ST_IDLE;
                  done     = 1'b1;
               end
               ST_RHIGH: begin
                  shifter = {shifter[6:0], w.sda_in};
                  scl_low = 1'b1;
                  enter(ST_RLOW);
               end
               ST_RLOW: begin
                  bits_done = bits_done + 1'b1;
                  scl_low   = 1'b0;
                  if (bits_done < BITS_PER_BYTE) begin
                     sda_low = 1'b0;
                     enter(ST_RHIGH);
                  end else begin
                     sda_low = !nack_held;
                     enter(ST_RACKH);
                  end
               end
               ST_RACKH: begin
                  scl_low = 1'b1;
                  enter(ST_RACKL);
               end
               ST_RACKL: begin
                  scl_low = 1'b1;
                  sda_low = 1'b1;
                  rx_held = shifter;
                  seq     = ST_IDLE;
                  done    = 1'b1;
               end
               default: seq = ST_IDLE;
            endcase
         end
         line_q.push_back('{scl_drive_low: scl_low, sda_drive_low: sda_low,
                            busy_res: (seq != ST_IDLE), done_res: done,
                            rx_byte: rx_held, ack_seen: ack_held});
      endfunction

      // compare one line word with the oldest prediction
      function void check_word(input rsp_type got);
         rsp_type want;
         if (line_q.size() == 0) begin
            flag($sformatf("unexpected word: scl %0b sda %0b busy %0b done %0b rx %02h ack %0b",
                           got.scl_drive_low, got.sda_drive_low, got.busy_res,
                           got.done_res, got.rx_byte, got.ack_seen));
            return;
         end
         want = line_q.pop_front();
         if (got.scl_drive_low !== want.scl_drive_low ||
             got.sda_drive_low !== want.sda_drive_low ||
             got.busy_res !== want.busy_res || got.done_res !== want.done_res ||
             got.rx_byte !== want.rx_byte || got.ack_seen !== want.ack_seen) begin
            flag($sformatf({"mismatch: expected scl %0b sda %0b busy %0b done %0b rx %02h",
                            " ack %0b, got scl %0b sda %0b busy %0b done %0b rx %02h ack %0b"},
                           want.scl_drive_low, want.sda_drive_low, want.busy_res,
                           want.done_res, want.rx_byte, want.ack_seen,
                           got.scl_drive_low, got.sda_drive_low, got.busy_res,
                           got.done_res, got.rx_byte, got.ack_seen));
         end
      endfunction
   endclass

endpackage

FILE: bench/i2c_master_byte_sequencer_tb.sv
module i2c_master_byte_sequencer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import i2cms_pkg::*;
   import i2cms_tb_pkg::*;

   localparam int STUCK_LIMIT = 2000;
   localparam int SDA_LOW     = 0;
   localparam int SDA_HIGH    = 1;
   localparam int SDA_RAND    = 2;

   logic clock = 1'b0;
   logic reset;

   i2cms_req_if req_ch();
   i2cms_rsp_if rsp_ch();
   i2cms_csr_if csr_ch();

   i2c_tick_scoreboard sb = new();

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int stuck_cycles       = 0;

   i2c_master_byte_sequencer i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // sda level for a given pattern mode
   function automatic logic pick_sda(input int mode);
      if (mode == SDA_RAND) return 1'($urandom_range(1));
      return (mode == SDA_HIGH);
   endfunction

   // offer one tick word, with random sender gaps in front of it
   task automatic send_word(input tick_word_type w);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid     <= 1'b0;
         req_ch.cmd_valid <= 1'($urandom_range(1));
         req_ch.action    <= 2'($urandom_range(3));
         req_ch.tx_byte   <= 8'($urandom_range(255));
         req_ch.send_nack <= 1'($urandom_range(1));
         req_ch.sda_in    <= 1'($urandom_range(1));
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.cmd_valid <= w.cmd_valid;
      req_ch.action    <= w.action;
      req_ch.tx_byte   <= w.tx_byte;
      req_ch.send_nack <= w.send_nack;
      req_ch.sda_in    <= w.sda_in;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_word(w);
   endtask

   // hold off the sender until every predicted word has come back
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // bring the sequencer to idle, drain, then write the half period
   task automatic write_half_period(input logic [HALF_PERIOD_W-1:0] value);
      tick_word_type w;
      while (!sb.idle()) begin
         w = '{cmd_valid: 1'b0, action: ACT_START, tx_byte: 8'h00, send_nack: 1'b0,
               sda_in: 1'($urandom_range(1))};
         send_word(w);
      end
      wait_drained();
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      sb.set_half_period(value);
   endtask

   // one command from idle, then ticks until the sequencer is idle again
   task automatic issue_cmd(input logic [1:0] act, input logic [7:0] byte_val,
                            input logic nack, input int sda_mode, input bit noise);
      tick_word_type w;
      w = '{cmd_valid: 1'b1, action: act, tx_byte: byte_val, send_nack: nack,
            sda_in: pick_sda(sda_mode)};
      send_word(w);
      while (!sb.idle()) begin
         // commands offered while busy must be ignored
         w.cmd_valid = noise ? 1'($urandom_range(1)) : 1'b0;
         w.action    = 2'($urandom_range(3));
         w.tx_byte   = 8'($urandom_range(255));
         w.send_nack = 1'($urandom_range(1));
         w.sda_in    = pick_sda(sda_mode);
         send_word(w);
      end
   endtask

   // random ticks: mostly whole bus transactions, some stray commands
   task automatic run_ticks(input int count);
      tick_word_type plan[$];
      tick_word_type w;
      logic [7:0]    addr;
      int            n_bytes;
      for (int i = 0; i < count; i++) begin
         w = '{cmd_valid: 1'b0, action: 2'($urandom_range(3)),
               tx_byte: 8'($urandom_range(255)), send_nack: 1'($urandom_range(1)),
               sda_in: 1'($urandom_range(1))};
         if (sb.idle()) begin
            if (plan.size() == 0) begin
               if ($urandom_range(9) < 2) begin
                  plan.push_back(w);
               end else begin
                  addr    = 8'($urandom_range(255));
                  n_bytes = $urandom_range(1, 3);
                  plan.push_back('{1'b1, ACT_START, 8'h00, 1'b0, 1'b1});
                  plan.push_back('{1'b1, ACT_WRITE, addr, 1'b0, 1'b1});
                  for (int j = 0; j < n_bytes; j++) begin
                     if (addr[0])
                        plan.push_back('{1'b1, ACT_READ, 8'h00, (j == n_bytes - 1), 1'b1});
                     else
                        plan.push_back('{1'b1, ACT_WRITE, 8'($urandom_range(255)), 1'b0,
                                         1'b1});
                  end
                  // sometimes leave the bus held for a repeated start
                  if ($urandom_range(3) != 0)
                     plan.push_back('{1'b1, ACT_STOP, 8'h00, 1'b0, 1'b1});
               end
            end
            if ($urandom_range(2) != 0) begin
               w = plan.pop_front();
               w.cmd_valid = 1'b1;
               w.sda_in    = 1'($urandom_range(1));
            end
         end else begin
            w.cmd_valid = ($urandom_range(3) == 0);
         end
         send_word(w);
         if (i == count / 2) wait_drained();
      end
   endtask

   // result side: check accepted words, random stalls
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_word({rsp_ch.scl_drive_low, rsp_ch.sda_drive_low, rsp_ch.busy_res,
                        rsp_ch.done_res, rsp_ch.rx_byte, rsp_ch.ack_seen});
      rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // watchdog on cycles with no handshake on any channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("i2c_master_byte_sequencer_tb: errors");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // main sequence
   initial begin
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.cmd_valid <= 1'b0;
      req_ch.action    <= ACT_START;
      req_ch.tx_byte   <= 8'h00;
      req_ch.send_nack <= 1'b0;
      req_ch.sda_in    <= 1'b1;
      csr_ch.valid     <= 1'b0;
      csr_ch.data      <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset half period first
      issue_cmd(ACT_STOP, 8'h00, 1'b0, SDA_RAND, 1'b0);

      // directed commands at the shortest period
      write_half_period(16'd1);
      issue_cmd(ACT_START, 8'h00, 1'b0, SDA_RAND, 1'b0);
      issue_cmd(ACT_WRITE, 8'h00, 1'b0, SDA_LOW, 1'b0);
      issue_cmd(ACT_WRITE, 8'hFF, 1'b0, SDA_HIGH, 1'b0);
      issue_cmd(ACT_WRITE, 8'hA5, 1'b1, SDA_RAND, 1'b1);
      issue_cmd(ACT_WRITE, 8'h5A, 1'b0, SDA_RAND, 1'b0);
      issue_cmd(ACT_READ, 8'h00, 1'b0, SDA_LOW, 1'b0);
      issue_cmd(ACT_READ, 8'hFF, 1'b1, SDA_HIGH, 1'b0);
      issue_cmd(ACT_READ, 8'h3C, 1'b0, SDA_RAND, 1'b1);
      issue_cmd(ACT_STOP, 8'h00, 1'b0, SDA_RAND, 1'b0);
      // stop with both lines already released
      issue_cmd(ACT_STOP, 8'hFF, 1'b1, SDA_RAND, 1'b1);
      // repeated start
      issue_cmd(ACT_START, 8'h00, 1'b0, SDA_RAND, 1'b0);
      issue_cmd(ACT_START, 8'h00, 1'b0, SDA_RAND, 1'b1);
      issue_cmd(ACT_READ, 8'h00, 1'b1, SDA_RAND, 1'b0);
      issue_cmd(ACT_STOP, 8'h00, 1'b0, SDA_RAND, 1'b0);

      // zero half period behaves as one
      write_half_period('0);
      issue_cmd(ACT_START, 8'h00, 1'b0, SDA_RAND, 1'b0);
      issue_cmd(ACT_WRITE, 8'($urandom_range(255)), 1'b0, SDA_RAND, 1'b1);
      issue_cmd(ACT_STOP, 8'h00, 1'b0, SDA_RAND, 1'b0);

      // longer period, one short command
      write_half_period(16'd60);
      issue_cmd(ACT_STOP, 8'h00, 1'b0, SDA_RAND, 1'b0);

      // random phases with different idling
      write_half_period(16'd1);
      run_ticks(290);

      sender_idle_pct = 58;
      write_half_period('0);
      run_ticks(290);

      sender_idle_pct    = 0;
      receiver_stall_pct = 58;
      write_half_period(16'($urandom_range(2, 3)));
      run_ticks(285);

      sender_idle_pct    = 21;
      receiver_stall_pct = 21;
      write_half_period(16'($urandom_range(1, 5)));
      run_ticks(285);

      wait_drained();
      repeat (4) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("i2c_master_byte_sequencer_tb: clean");
      else
         $display("i2c_master_byte_sequencer_tb: errors");
      $finish;
   end

endmodule
